### rtl/mavg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 7;
  // 7-bit window times 16-bit sample needs 23 bits signed
  localparam int SUM_W     = SAMPLE_W + CNT_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_OUT
  } mavg_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/mavg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/mavg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mavg_div
  import mavg_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [SUM_W-1:0]    dividend_i,
  input  wire logic        [CNT_W-1:0]    divisor_i,
  output div_stat_t                       stat_o,
  output logic signed      [SAMPLE_W-1:0] quotient_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [SUM_W-1:0]  quo_signed;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIV_STEPS);
      neg_d  = dividend_i[SUM_W-1];
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
    end else if (busy_q) begin
      // one restoring step: shift in next dividend bit, subtract if it fits
      rem_d  = ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // restore sign: truncation toward zero
  assign quo_signed  = neg_q ? SUM_W'(-quo_q) : quo_q;
  assign quotient_o  = quo_signed[SAMPLE_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

### rtl/moving_average_filter_core.sv
// Moving average core: one item in, one mean out.
// An accepted item passes through ST_UPD (table update), then a 23-step
// restoring divider shared for every mean, then ST_OUT to the output register.
// No new item is taken before the last one has reached the output register;
// in_stall_o is high while an item is at work.
// Reset: window 8 (capped at MAX_WINDOW), history empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter_core
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic        [CNT_W-1:0]    cfg_window_size_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed      [SAMPLE_W-1:0] average_o,
  output logic             [CNT_W-1:0]    held_count_o
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [CNT_W-1:0] WIN_CAP =
      (MAX_WINDOW > (2**CNT_W - 1)) ? CNT_W'(2**CNT_W - 1) : CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] WIN_RST = (WIN_CAP < CNT_W'(8)) ? WIN_CAP : CNT_W'(8);

  mavg_state_e state_q, state_d;

  logic        [CNT_W-1:0]    win_q, win_d;
  logic        [CNT_W-1:0]    oldest_q, oldest_d;
  logic        [CNT_W-1:0]    fill_q, fill_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] avg_q;
  logic        [CNT_W-1:0]    held_q;

  logic                       in_acc;
  logic                       cfg_acc;
  logic                       out_free;
  logic                       out_load;
  logic        [CNT_W-1:0]    win_sat;
  logic        [CNT_W-1:0]    oldest_eff;
  logic        [CNT_W:0]      slot_sum;
  logic        [CNT_W-1:0]    slot;
  logic        [CNT_W-1:0]    oldest_inc;
  logic                       full;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic                       ram_we;
  logic        [AW-1:0]       ram_waddr;
  logic                       div_start;
  div_stat_t                  div_stat;
  logic signed [SAMPLE_W-1:0] div_quo;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign win_sat = (cfg_window_size_i == '0) ? CNT_W'(1) :
                   (cfg_window_size_i > WIN_CAP) ? WIN_CAP : cfg_window_size_i;

  assign oldest_eff = (oldest_q >= win_q) ? '0 : oldest_q;
  assign full       = fill_q >= win_q;
  assign slot_sum   = {1'b0, oldest_eff} + {1'b0, fill_q};
  assign slot       = (slot_sum >= {1'b0, win_q}) ? CNT_W'(slot_sum - {1'b0, win_q})
                                                  : slot_sum[CNT_W-1:0];
  assign oldest_inc = (oldest_eff + CNT_W'(1) == win_q) ? '0 : oldest_eff + CNT_W'(1);

  mavg_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_WINDOW),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(sample_q),
    .re_i   (in_acc),
    .raddr_i(AW'(oldest_eff)),
    .rdata_o(old_sample)
  );

  mavg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_d),
    .divisor_i (fill_d),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = AW'(slot);
    div_start   = 1'b0;
    out_load    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // old sample read back from the store is valid here
        ram_we    = 1'b1;
        div_start = 1'b1;
        oldest_d  = oldest_eff;
        if (!full) begin
          ram_waddr = AW'(slot);
          fill_d    = fill_q + CNT_W'(1);
          sum_d     = sum_q + SUM_W'(sample_q);
        end else begin
          ram_waddr = AW'(oldest_eff);
          sum_d     = sum_q + SUM_W'(sample_q) - SUM_W'(old_sample);
          oldest_d  = oldest_inc;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the mean until the output register frees up
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      win_d    = win_sat;
      oldest_d = '0;
      fill_d   = '0;
      sum_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RST;
      oldest_q    <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_i;
    end
    if (out_load) begin
      avg_q  <= div_quo;
      held_q <= fill_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = avg_q;
  assign held_count_o = held_q;

endmodule

`default_nettype wire

### rtl/mavg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mavg_checker
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic        [CNT_W-1:0]    cfg_window_size_i,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic signed [SAMPLE_W-1:0] sample_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic signed [SAMPLE_W-1:0] average_o,
  input wire logic        [CNT_W-1:0]    held_count_o
);

  localparam logic [CNT_W-1:0] WIN_CAP =
      (MAX_WINDOW > (2**CNT_W - 1)) ? CNT_W'(2**CNT_W - 1) : CNT_W'(MAX_WINDOW);

  logic unused_cfg;
  assign unused_cfg = cfg_valid_i ^ cfg_ready_o ^ (^cfg_window_size_i) ^ (^sample_i);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=>
        out_valid_o && $stable(average_o) && $stable(held_count_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (held_count_o != '0) && (held_count_o <= WIN_CAP))
    else $error("held_count out of range");

  // an accepted item keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind moving_average_filter_core mavg_checker #(
  .MAX_WINDOW(MAX_WINDOW)
) u_mavg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_valid_i      (cfg_valid_i),
  .cfg_ready_o      (cfg_ready_o),
  .cfg_window_size_i(cfg_window_size_i),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .sample_i         (sample_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .average_o        (average_o),
  .held_count_o     (held_count_o)
);

`default_nettype wire

### verif/moving_average_filter_core_test.sv
`timescale 1ns / 1ps

module moving_average_filter_core_test;
  import mavg_pkg::*;

  localparam int MAX_WIN    = 64;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_LEN  = 185;
  localparam int DRAIN_WAIT = 40;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_SPARSE} stall_mode_e;

  typedef struct {
    row_kind_e                  kind;
    logic signed [SAMPLE_W-1:0] val;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] avg;
    logic        [CNT_W-1:0]    cnt;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] avg;
    logic        [CNT_W-1:0]    cnt;
  } mean_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic        [CNT_W-1:0]    cfg_window_size_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] average_o;
  logic        [CNT_W-1:0]    held_count_o;

  // predictor state
  logic signed [SAMPLE_W-1:0] hist_ring [MAX_WIN];
  int                         hist_head;
  int                         hist_fill;
  int                         hist_sum;
  logic        [CNT_W-1:0]    win_setting;

  mean_t     pending_means [$];
  stim_row_t dir_tab [$];
  int        errors;
  int        cycles;
  int        burst_left;
  bit        hold_req;

  moving_average_filter_core #(
    .MAX_WINDOW(MAX_WIN)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_window_size_i(cfg_window_size_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .average_o        (average_o),
    .held_count_o     (held_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void clear_history();
    hist_head = 0;
    hist_fill = 0;
    hist_sum  = 0;
  endfunction

  // Advance the window by one sample and return the mean it yields.
  function automatic mean_t predict_mean(logic signed [SAMPLE_W-1:0] s);
    mean_t r;
    int    w;
    int    slot;
    int    quot;
    w = int'(win_setting);
    if (w < 1) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    if (hist_head >= w) hist_head = 0;
    if (hist_fill < w) begin
      slot = (hist_head + hist_fill) % w;
      hist_ring[slot] = s;
      hist_fill++;
      hist_sum += int'(s);
    end else begin
      hist_sum -= int'(hist_ring[hist_head]);
      hist_ring[hist_head] = s;
      hist_sum += int'(s);
      hist_head = (hist_head + 1) % w;
    end
    quot  = hist_sum / hist_fill;
    r.avg = quot[SAMPLE_W-1:0];
    r.cnt = hist_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_kind_e kind, int val, int typed = 0,
                                       int avg = 0, int cnt = 0);
    stim_row_t r;
    r.kind  = kind;
    r.val   = val[SAMPLE_W-1:0];
    r.typed = (typed != 0);
    r.avg   = avg[SAMPLE_W-1:0];
    r.cnt   = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(0, 511) - 256);
      3:       return 16'sh7fff - 16'($urandom_range(0, 15));
      4:       return 16'sh8000 + 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; leaves valid high for the next item.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit typed = 1'b0,
                             logic signed [SAMPLE_W-1:0] exp_avg = '0,
                             logic [CNT_W-1:0] exp_cnt = '0);
    mean_t r;
    int    gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        in_valid_i = 1'b0;
        sample_i   = 16'($urandom);
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    sample_i   = s;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    r = predict_mean(s);
    if (typed) begin
      r.avg = exp_avg;
      r.cnt = exp_cnt;
    end
    pending_means.push_back(r);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drain all means, then write the window register.
  task automatic write_window(logic [CNT_W-1:0] w);
    in_valid_i = 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    cfg_valid_i       = 1'b1;
    cfg_window_size_i = w;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    win_setting = w;
    clear_history();
    @(negedge clk_i);
    cfg_valid_i       = 1'b0;
    cfg_window_size_i = CNT_W'($urandom);
  endtask

  always @(posedge clk_i) begin : check_out
    mean_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected item average=%0d held_count=%0d",
                 $time, average_o, held_count_o);
        errors++;
      end else begin
        e = pending_means.pop_front();
        if (average_o !== e.avg) begin
          $display("%0t: average expected %0d got %0d", $time, e.avg, average_o);
          errors++;
        end
        if (held_count_o !== e.cnt) begin
          $display("%0t: held_count expected %0d got %0d", $time, e.cnt, held_count_o);
          errors++;
        end
      end
    end
  end

  // Output side: stall in changing patterns, plus one long hold-off on request.
  initial begin : out_side
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          tick;
    mode        = STALL_NONE;
    mode_left   = 0;
    hold_left   = 0;
    tick        = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE:     out_stall_i = 1'b0;
          STALL_COIN:     out_stall_i = 1'($urandom_range(0, 1));
          STALL_PERIODIC: out_stall_i = (tick % 7) < 3;
          default:        out_stall_i = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin : in_side
    logic [CNT_W-1:0] phase_win [10];
    stim_row_t        row;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_window_size_i = '0;
    in_valid_i        = 1'b0;
    sample_i          = '0;
    errors            = 0;
    cycles            = 0;
    burst_left        = 0;
    hold_req          = 1'b0;
    win_setting       = 7'd8;
    clear_history();

    // after reset the window is 8
    dir_tab.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 1));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -32768, 1, 0, 2));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -32768, 1, -10923, 3));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 256));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 512));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -1));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 1));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 100));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -100));
    // zero acts as a window of one
    dir_tab.push_back(mk_row(ROW_WINDOW, 0));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -1, 1, -1, 1));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 32767, 1, 32767, 1));
    // values above the maximum clamp to it
    dir_tab.push_back(mk_row(ROW_WINDOW, 127));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -32768, 1, -32768, 1));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -32768, 1, -32768, 2));
    dir_tab.push_back(mk_row(ROW_WINDOW, 65));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 1, 1, 1, 1));
    dir_tab.push_back(mk_row(ROW_WINDOW, 2));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 3));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 4));
    dir_tab.push_back(mk_row(ROW_SAMPLE, -7));
    // rewriting the same value still clears the history
    dir_tab.push_back(mk_row(ROW_WINDOW, 2));
    dir_tab.push_back(mk_row(ROW_SAMPLE, 5, 1, 5, 1));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_WINDOW) write_window(row.val[CNT_W-1:0]);
      else send_sample(row.val, row.typed, row.avg, row.cnt);
    end

    phase_win = '{7'd64, 7'd0, 7'd127, 7'd5, 7'd65, 7'd1,
                  CNT_W'($urandom_range(1, 127)), CNT_W'($urandom_range(2, 12)),
                  7'd63, 7'd8};
    foreach (phase_win[p]) begin
      write_window(phase_win[p]);
      // fill the block while the output side holds off
      if (p == 0) hold_req = 1'b1;
      repeat (PHASE_LEN) send_sample(rand_sample());
    end

    in_valid_i = 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
